>>> src/euler_rusanov_interface_flux_unit_macros.svh
// assertion helpers for the interface flux unit
`ifndef EULER_RUSANOV_INTERFACE_FLUX_UNIT_MACROS_SVH
`define EULER_RUSANOV_INTERFACE_FLUX_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ERIF_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("interface flux unit check failed");

// next-cycle implication, disabled in reset
`define ERIF_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("interface flux unit check failed");

`endif

>>> src/erif_pkg.sv
`default_nettype none
package erif_pkg;

  localparam int Q_W    = 32;
  localparam int SLOT_W = 6;
  localparam int SLOTS  = 64;
  localparam int PC_W   = 6;
  localparam int ITERS  = 24;
  localparam int CNT_W  = 5;

  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;
  localparam logic signed [31:0] Q_ONE = 32'sd65536;

  // configuration register indexes
  localparam logic [2:0] REG_GAMMA  = 3'd0;
  localparam logic [2:0] REG_CFL    = 3'd1;
  localparam logic [2:0] REG_WIDTH  = 3'd2;
  localparam logic [2:0] REG_HEIGHT = 3'd3;
  localparam logic [2:0] REG_START  = 3'd4;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_HALF = 3'd4,
    OP_SQRT = 3'd5,
    OP_ABS  = 3'd6,
    OP_MAX  = 3'd7
  } op_t;

  // per-side slots (side 1 sits SIDE1 higher)
  localparam logic [5:0] S_RHO = 6'd0;
  localparam logic [5:0] S_MX  = 6'd1;
  localparam logic [5:0] S_MY  = 6'd2;
  localparam logic [5:0] S_E   = 6'd3;
  localparam logic [5:0] S_MN  = 6'd4;
  localparam logic [5:0] S_MT  = 6'd5;
  localparam logic [5:0] S_T1  = 6'd6;
  localparam logic [5:0] S_T2  = 6'd7;
  localparam logic [5:0] S_P   = 6'd8;
  localparam logic [5:0] S_VEL = 6'd9;
  localparam logic [5:0] S_F1  = 6'd10;
  localparam logic [5:0] S_F2  = 6'd11;
  localparam logic [5:0] S_FE  = 6'd12;
  localparam logic [5:0] S_LAM = 6'd13;
  localparam logic [5:0] SIDE1 = 6'd16;
  // shared slots
  localparam logic [5:0] S_GAM  = 6'd32;
  localparam logic [5:0] S_ONE  = 6'd33;
  localparam logic [5:0] S_GM1  = 6'd34;
  localparam logic [5:0] S_CFL  = 6'd35;
  localparam logic [5:0] S_H    = 6'd36;
  localparam logic [5:0] S_LMAX = 6'd37;
  localparam logic [5:0] S_A    = 6'd38;
  localparam logic [5:0] S_B    = 6'd39;
  localparam logic [5:0] S_C    = 6'd40;
  localparam logic [5:0] S_OUT0 = 6'd41;
  localparam logic [5:0] S_OUT1 = 6'd42;
  localparam logic [5:0] S_OUT2 = 6'd43;
  localparam logic [5:0] S_OUT3 = 6'd44;

  // program layout
  localparam logic [5:0] PC_SIDE_BEG = 6'd1;
  localparam logic [5:0] PC_SIDE_END = 6'd20;
  localparam logic [5:0] PC_LAST     = 6'd51;

  typedef struct packed {
    op_t        op;
    logic [5:0] a;
    logic [5:0] b;
    logic [5:0] d;
    logic       swap;  // swap normal and tangential slot for y
    logic       chk;   // result must be positive
  } uop_t;

  function automatic uop_t mk(op_t op, logic [5:0] a, logic [5:0] b, logic [5:0] d,
                              logic swap, logic chk);
    uop_t u;
    u.op = op; u.a = a; u.b = b; u.d = d; u.swap = swap; u.chk = chk;
    return u;
  endfunction

  // microprogram
  function automatic uop_t prog(logic [5:0] pc);
    uop_t u;
    u = mk(OP_ADD, S_A, S_A, S_A, 1'b0, 1'b0);
    case (pc)
      6'd0:  u = mk(OP_SUB,  S_GAM, S_ONE, S_GM1, 1'b0, 1'b0);
      // one side
      6'd1:  u = mk(OP_MUL,  S_MX,  S_MX,  S_T1,  1'b0, 1'b0);
      6'd2:  u = mk(OP_MUL,  S_MY,  S_MY,  S_T2,  1'b0, 1'b0);
      6'd3:  u = mk(OP_ADD,  S_T1,  S_T2,  S_T1,  1'b0, 1'b0);
      6'd4:  u = mk(OP_DIV,  S_T1,  S_RHO, S_T1,  1'b0, 1'b0);
      6'd5:  u = mk(OP_HALF, S_T1,  S_T1,  S_T1,  1'b0, 1'b0);
      6'd6:  u = mk(OP_SUB,  S_E,   S_T1,  S_T1,  1'b0, 1'b0);
      6'd7:  u = mk(OP_MUL,  S_T1,  S_GM1, S_P,   1'b0, 1'b1);
      6'd8:  u = mk(OP_DIV,  S_MN,  S_RHO, S_VEL, 1'b0, 1'b0);
      6'd9:  u = mk(OP_MUL,  S_MN,  S_MN,  S_T1,  1'b0, 1'b0);
      6'd10: u = mk(OP_DIV,  S_T1,  S_RHO, S_T1,  1'b0, 1'b0);
      6'd11: u = mk(OP_ADD,  S_T1,  S_P,   S_F1,  1'b1, 1'b0);
      6'd12: u = mk(OP_MUL,  S_MN,  S_MT,  S_T1,  1'b0, 1'b0);
      6'd13: u = mk(OP_DIV,  S_T1,  S_RHO, S_F2,  1'b1, 1'b0);
      6'd14: u = mk(OP_ADD,  S_E,   S_P,   S_T1,  1'b0, 1'b0);
      6'd15: u = mk(OP_MUL,  S_VEL, S_T1,  S_FE,  1'b0, 1'b0);
      6'd16: u = mk(OP_MUL,  S_GAM, S_P,   S_T1,  1'b0, 1'b0);
      6'd17: u = mk(OP_DIV,  S_T1,  S_RHO, S_T1,  1'b0, 1'b0);
      6'd18: u = mk(OP_SQRT, S_T1,  S_T1,  S_T1,  1'b0, 1'b0);
      6'd19: u = mk(OP_ABS,  S_VEL, S_VEL, S_T2,  1'b0, 1'b0);
      6'd20: u = mk(OP_ADD,  S_T2,  S_T1,  S_LAM, 1'b0, 1'b0);
      // interface combination, absolute slots
      6'd21: u = mk(OP_MAX,  S_LAM, S_LAM + SIDE1, S_LMAX, 1'b0, 1'b0);
      6'd22: u = mk(OP_ADD,  S_MN,  S_MN + SIDE1,  S_A, 1'b0, 1'b0);
      6'd23: u = mk(OP_HALF, S_A,   S_A,   S_A,    1'b0, 1'b0);
      6'd24: u = mk(OP_SUB,  S_RHO + SIDE1, S_RHO, S_B, 1'b0, 1'b0);
      6'd25: u = mk(OP_MUL,  S_LMAX, S_B,  S_B,    1'b0, 1'b0);
      6'd26: u = mk(OP_HALF, S_B,   S_B,   S_B,    1'b0, 1'b0);
      6'd27: u = mk(OP_SUB,  S_A,   S_B,   S_A,    1'b0, 1'b0);
      6'd28: u = mk(OP_DIV,  S_A,   S_H,   S_OUT0, 1'b0, 1'b0);
      6'd29: u = mk(OP_ADD,  S_F1,  S_F1 + SIDE1,  S_A, 1'b0, 1'b0);
      6'd30: u = mk(OP_HALF, S_A,   S_A,   S_A,    1'b0, 1'b0);
      6'd31: u = mk(OP_SUB,  S_MX + SIDE1, S_MX, S_B, 1'b0, 1'b0);
      6'd32: u = mk(OP_MUL,  S_LMAX, S_B,  S_B,    1'b0, 1'b0);
      6'd33: u = mk(OP_HALF, S_B,   S_B,   S_B,    1'b0, 1'b0);
      6'd34: u = mk(OP_SUB,  S_A,   S_B,   S_A,    1'b0, 1'b0);
      6'd35: u = mk(OP_DIV,  S_A,   S_H,   S_OUT1, 1'b0, 1'b0);
      6'd36: u = mk(OP_ADD,  S_F2,  S_F2 + SIDE1,  S_A, 1'b0, 1'b0);
      6'd37: u = mk(OP_HALF, S_A,   S_A,   S_A,    1'b0, 1'b0);
      6'd38: u = mk(OP_SUB,  S_MY + SIDE1, S_MY, S_B, 1'b0, 1'b0);
      6'd39: u = mk(OP_MUL,  S_LMAX, S_B,  S_B,    1'b0, 1'b0);
      6'd40: u = mk(OP_HALF, S_B,   S_B,   S_B,    1'b0, 1'b0);
      6'd41: u = mk(OP_SUB,  S_A,   S_B,   S_A,    1'b0, 1'b0);
      6'd42: u = mk(OP_DIV,  S_A,   S_H,   S_OUT2, 1'b0, 1'b0);
      6'd43: u = mk(OP_ADD,  S_FE,  S_FE + SIDE1,  S_A, 1'b0, 1'b0);
      6'd44: u = mk(OP_HALF, S_A,   S_A,   S_A,    1'b0, 1'b0);
      6'd45: u = mk(OP_SUB,  S_E + SIDE1, S_E, S_B,  1'b0, 1'b0);
      6'd46: u = mk(OP_MUL,  S_LMAX, S_B,  S_B,    1'b0, 1'b0);
      6'd47: u = mk(OP_HALF, S_B,   S_B,   S_B,    1'b0, 1'b0);
      6'd48: u = mk(OP_SUB,  S_A,   S_B,   S_A,    1'b0, 1'b0);
      6'd49: u = mk(OP_DIV,  S_A,   S_H,   S_OUT3, 1'b0, 1'b0);
      // time step candidate
      6'd50: u = mk(OP_MUL,  S_CFL, S_H,   S_C,    1'b0, 1'b0);
      6'd51: u = mk(OP_DIV,  S_C,   S_LMAX, S_C,   1'b0, 1'b0);
      default: u = mk(OP_ADD, S_A, S_A, S_A, 1'b0, 1'b0);
    endcase
    return u;
  endfunction

  // saturate a 33-bit sum
  function automatic logic signed [31:0] qsat33(logic signed [32:0] s);
    if (s > 33'sh0_7fffffff) return Q_MAX;
    if (s < -33'sh0_80000000) return Q_MIN;
    return s[31:0];
  endfunction

  function automatic logic [31:0] mag32(logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // apply sign to a magnitude, saturated
  function automatic logic signed [31:0] sgn_of(logic [47:0] m, logic neg);
    logic [31:0] mc;
    mc = (m > 48'h8000_0000) ? 32'h8000_0000 : m[31:0];
    if (neg) return 32'(-mc);
    if (mc == 32'h8000_0000) return Q_MAX;
    return mc;
  endfunction

endpackage
`default_nettype wire

>>> src/erif_ram.sv
`default_nettype none
module erif_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

>>> src/euler_rusanov_interface_flux_unit.sv
`default_nettype none
`include "euler_rusanov_interface_flux_unit_macros.svh"
// Rusanov interface flux for the 2-D Euler equations in signed Q16.16. One
// interface is taken at a time: in_ready is high only while the unit is idle,
// and a finished result sits in the output registers so the next interface
// can be taken while it waits. An interface is handled in two parts: a
// load of both states into a 64-word scratch RAM, then a 52-step
// microprogram on one shared arithmetic unit. Add, subtract, multiply, halve,
// abs and max each take a RAM read and an execute step; each of the 15
// divisions (radix-2, two quotient bits a cycle) and 2 square roots (one root
// bit a cycle) adds iterative steps and a write-back step. A division by zero
// or a root of a non-positive value skips the iteration. Configuration
// writes are accepted at any time and must only be issued while idle.
module euler_rusanov_interface_flux_unit
  import erif_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               func,
  input  wire logic signed [31:0] left_density,
  input  wire logic signed [31:0] left_mom_x,
  input  wire logic signed [31:0] left_mom_y,
  input  wire logic signed [31:0] left_energy,
  input  wire logic signed [31:0] right_density,
  input  wire logic signed [31:0] right_mom_x,
  input  wire logic signed [31:0] right_mom_y,
  input  wire logic signed [31:0] right_energy,
  input  wire logic               new_sweep,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      flux_density,
  output logic signed [31:0]      flux_mom_x,
  output logic signed [31:0]      flux_mom_y,
  output logic signed [31:0]      flux_energy,
  output logic        [30:0]      wave_speed,
  output logic        [30:0]      step_min,
  output logic                    bad_state,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_LOAD = 7'b0000010,
    ST_RD   = 7'b0000100,
    ST_EX   = 7'b0001000,
    ST_ITER = 7'b0010000,
    ST_WR   = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

  state_t state, state_next;

  // configuration
  logic [17:0] gas_gamma;
  logic [16:0] cfl_number;
  logic [30:0] cell_width;
  logic [30:0] cell_height;
  logic [30:0] start_step;
  logic [30:0] running_step;

  // latched item
  logic signed [31:0] u_st [2][4];
  logic               ydir;
  logic               sweep;
  logic               bad_acc;

  // sequencer
  logic [3:0]       load_cnt;
  logic [PC_W-1:0]  pc;
  logic             side;
  logic [CNT_W-1:0] iter_cnt;
  logic             unit_sqrt;
  logic             unit_neg;

  // shared iterative unit
  logic [47:0] dq;
  logic [31:0] dd;
  logic [31:0] drem;
  logic [47:0] sx;
  logic [47:0] sr;
  logic [47:0] sb;

  // staged results
  logic signed [31:0] flux_stage [4];
  logic signed [31:0] lmax_stage;
  logic signed [31:0] cand_stage;

  uop_t               uop;
  logic               in_side;
  logic [SLOT_W-1:0]  ra, rb, wa, dmap;
  logic               we;
  logic signed [31:0] wd, rd_a, rd_b;
  logic signed [31:0] alu_res, load_data, unit_res;
  logic [SLOT_W-1:0]  load_addr;
  logic               is_long;
  logic [31:0]        ma, mb;
  logic [63:0]        prod;
  logic signed [32:0] sum, dif, hlf;
  logic [47:0]        dq_n;
  logic [31:0]        drem_n;
  logic [47:0]        sx_n, sr_n, st;
  logic               out_fire;
  logic               op_done;
  logic [30:0]        cand_eff, run_base;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_fire  = (state == ST_FIN) && (!out_valid || out_ready);

  // slot mapping: side-local slots are offset by the side under work
  function automatic logic [SLOT_W-1:0] map_slot(logic [5:0] s, logic in_s, logic sd);
    return (in_s && !s[5] && !s[4]) ? {1'b0, sd, s[3:0]} : s;
  endfunction

  always_comb begin
    uop     = prog(pc);
    in_side = (pc >= PC_SIDE_BEG) && (pc <= PC_SIDE_END);
    ra      = map_slot(uop.a, in_side, side);
    rb      = map_slot(uop.b, in_side, side);
    dmap    = map_slot(uop.d ^ {5'd0, uop.swap & ydir}, in_side, side);
  end

  erif_ram #(.WIDTH(Q_W), .DEPTH(SLOTS)) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (wa),
    .wdata   (wd),
    .raddr_a (ra),
    .raddr_b (rb),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // load sequence: per side rho, mx, my, e, normal, tangential, then shared
  always_comb begin
    load_addr = {1'b0, load_cnt[3], 1'b0, load_cnt[2:0]};
    case (load_cnt[2:0])
      3'd0: load_data = u_st[load_cnt[3]][0];
      3'd1: load_data = u_st[load_cnt[3]][1];
      3'd2: load_data = u_st[load_cnt[3]][2];
      3'd3: load_data = u_st[load_cnt[3]][3];
      3'd4: load_data = ydir ? u_st[load_cnt[3]][2] : u_st[load_cnt[3]][1];
      3'd5: load_data = ydir ? u_st[load_cnt[3]][1] : u_st[load_cnt[3]][2];
      3'd6: begin
        load_data = load_cnt[3] ? {15'd0, cfl_number} : {14'd0, gas_gamma};
        load_addr = load_cnt[3] ? S_CFL : S_GAM;
      end
      default: begin
        load_data = load_cnt[3] ? {1'b0, (ydir ? cell_height : cell_width)} : Q_ONE;
        load_addr = load_cnt[3] ? S_H : S_ONE;
      end
    endcase
  end

  // combinational operations
  always_comb begin
    ma   = mag32(rd_a);
    mb   = mag32(rd_b);
    prod = 64'(ma) * 64'(mb);
    sum  = 33'(rd_a) + 33'(rd_b);
    dif  = 33'(rd_a) - 33'(rd_b);
    hlf  = (33'(rd_a) + {32'd0, rd_a[31]}) >>> 1;
    is_long = ((uop.op == OP_DIV) && (rd_b != 0)) || ((uop.op == OP_SQRT) && (rd_a > 0));
    case (uop.op)
      OP_ADD:  alu_res = qsat33(sum);
      OP_SUB:  alu_res = qsat33(dif);
      OP_MUL:  alu_res = sgn_of(prod[63:16], rd_a[31] ^ rd_b[31]);
      OP_HALF: alu_res = hlf[31:0];
      OP_ABS:  alu_res = sgn_of({16'd0, ma}, 1'b0);
      OP_MAX:  alu_res = (rd_a > rd_b) ? rd_a : rd_b;
      OP_DIV:  alu_res = (rd_a == 0) ? 32'sd0 : (rd_a[31] ? Q_MIN : Q_MAX);
      OP_SQRT: alu_res = 32'sd0;
      default: alu_res = rd_a;
    endcase
  end

  // two restoring division steps and one root step a cycle
  always_comb begin
    logic [32:0] r;
    dq_n   = dq;
    drem_n = drem;
    for (int k = 0; k < 2; k++) begin
      r = {drem_n, dq_n[47]};
      if (r >= {1'b0, dd}) begin
        r      = r - {1'b0, dd};
        dq_n   = {dq_n[46:0], 1'b1};
      end else begin
        dq_n   = {dq_n[46:0], 1'b0};
      end
      drem_n = r[31:0];
    end
    st = sr + sb;
    if (sx >= st) begin
      sx_n = sx - st;
      sr_n = (sr >> 1) + sb;
    end else begin
      sx_n = sx;
      sr_n = sr >> 1;
    end
    unit_res = unit_sqrt ? sr[31:0] : sgn_of(dq, unit_neg);
  end

  // write port
  always_comb begin
    we = 1'b0;
    wa = dmap;
    wd = alu_res;
    case (state)
      ST_LOAD: begin
        we = 1'b1;
        wa = load_addr;
        wd = load_data;
      end
      ST_EX: we = !is_long;
      ST_WR: begin
        we = 1'b1;
        wd = unit_res;
      end
      default: we = 1'b0;
    endcase
  end

  assign op_done = ((state == ST_EX) && !is_long) || (state == ST_WR);

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_LOAD;
      ST_LOAD: if (load_cnt == 4'hf) state_next = ST_RD;
      ST_RD:   state_next = ST_EX;
      ST_EX: begin
        if (is_long) state_next = ST_ITER;
        else if (pc == PC_LAST) state_next = ST_FIN;
        else state_next = ST_RD;
      end
      ST_ITER: if (iter_cnt == CNT_W'(ITERS - 1)) state_next = ST_WR;
      ST_WR:   state_next = (pc == PC_LAST) ? ST_FIN : ST_RD;
      ST_FIN:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gas_gamma   <= 18'd91750;
      cfl_number  <= 17'd32768;
      cell_width  <= 31'd65536;
      cell_height <= 31'd65536;
      start_step  <= 31'h7fffffff;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GAMMA:  gas_gamma   <= cfg_data[17:0];
        REG_CFL:    cfl_number  <= cfg_data[16:0];
        REG_WIDTH:  cell_width  <= cfg_data[30:0];
        REG_HEIGHT: cell_height <= cfg_data[30:0];
        REG_START:  start_step  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // item capture, program counter and bad-state flag
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      u_st[0][0] <= left_density;
      u_st[0][1] <= left_mom_x;
      u_st[0][2] <= left_mom_y;
      u_st[0][3] <= left_energy;
      u_st[1][0] <= right_density;
      u_st[1][1] <= right_mom_x;
      u_st[1][2] <= right_mom_y;
      u_st[1][3] <= right_energy;
      ydir       <= func;
      sweep      <= new_sweep;
      bad_acc    <= 1'b0;
      load_cnt   <= 4'd0;
      pc         <= '0;
      side       <= 1'b0;
    end else begin
      if (state == ST_LOAD) begin
        load_cnt <= load_cnt + 4'd1;
        if ((load_cnt[2:0] == 3'd0) && (load_data <= 0)) bad_acc <= 1'b1;
      end
      if (op_done) begin
        if (uop.chk && (wd <= 0)) bad_acc <= 1'b1;
        if ((pc == PC_SIDE_END) && !side) begin
          side <= 1'b1;
          pc   <= PC_SIDE_BEG;
        end else begin
          pc <= pc + PC_W'(1);
        end
      end
    end
  end

  // shared divide and root unit
  always_ff @(posedge clk) begin
    if (state == ST_EX) begin
      iter_cnt  <= '0;
      unit_sqrt <= (uop.op == OP_SQRT);
      unit_neg  <= rd_a[31] ^ rd_b[31];
      dq        <= {ma, 16'd0};
      dd        <= mb;
      drem      <= '0;
      sx        <= {rd_a, 16'd0};
      sr        <= '0;
      sb        <= 48'd1 << 46;
    end else if (state == ST_ITER) begin
      iter_cnt <= iter_cnt + CNT_W'(1);
      dq       <= dq_n;
      drem     <= drem_n;
      sx       <= sx_n;
      sr       <= sr_n;
      sb       <= sb >> 2;
    end
  end

  // pick results off the write port
  always_ff @(posedge clk) begin
    if (we && (state != ST_LOAD)) begin
      case (wa)
        S_OUT0: flux_stage[0] <= wd;
        S_OUT1: flux_stage[1] <= wd;
        S_OUT2: flux_stage[2] <= wd;
        S_OUT3: flux_stage[3] <= wd;
        S_LMAX: lmax_stage    <= wd;
        S_C:    cand_stage    <= wd;
        default: ;
      endcase
    end
  end

  // step fold
  always_comb begin
    run_base = sweep ? start_step : running_step;
    if (lmax_stage == 0) cand_eff = 31'h7fffffff;
    else if (cand_stage < 0) cand_eff = '0;
    else cand_eff = cand_stage[30:0];
  end

  // output registers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      running_step <= 31'h7fffffff;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (out_fire) begin
        out_valid    <= 1'b1;
        running_step <= (cand_eff < run_base) ? cand_eff : run_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      flux_density <= flux_stage[0];
      flux_mom_x   <= flux_stage[1];
      flux_mom_y   <= flux_stage[2];
      flux_energy  <= flux_stage[3];
      wave_speed   <= lmax_stage[30:0];
      step_min     <= (cand_eff < run_base) ? cand_eff : run_base;
      bad_state    <= bad_acc;
    end
  end

  // checks
  `ERIF_ASSERT_NXT(a_accept_loads, in_valid && in_ready, state == ST_LOAD)
  `ERIF_ASSERT_NXT(a_iter_ends, (state == ST_ITER) && (iter_cnt == 5'(ITERS - 1)), state == ST_WR)
  `ERIF_ASSERT_NXT(a_fire_shows, out_fire, out_valid && (state == ST_IDLE))
  `ERIF_ASSERT_IMP(a_pc_range, state == ST_RD, pc <= PC_LAST)

endmodule
`default_nettype wire

>>> bench/rusanov_flux_checker.sv
`timescale 1ns / 1ps
module rusanov_flux_checker
  import erif_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               func,
  input  logic signed [31:0] left_density,
  input  logic signed [31:0] left_mom_x,
  input  logic signed [31:0] left_mom_y,
  input  logic signed [31:0] left_energy,
  input  logic signed [31:0] right_density,
  input  logic signed [31:0] right_mom_x,
  input  logic signed [31:0] right_mom_y,
  input  logic signed [31:0] right_energy,
  input  logic               new_sweep,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] flux_density,
  input  logic signed [31:0] flux_mom_x,
  input  logic signed [31:0] flux_mom_y,
  input  logic signed [31:0] flux_energy,
  input  logic        [30:0] wave_speed,
  input  logic        [30:0] step_min,
  input  logic               bad_state,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 errors,
  output int                 pending
);

  localparam longint QHI  = 64'sd2147483647;
  localparam longint QLO  = -64'sd2147483648;
  localparam longint UNIT = 64'sd65536;

  typedef struct packed {
    logic signed [31:0] fd;
    logic signed [31:0] fmx;
    logic signed [31:0] fmy;
    logic signed [31:0] fe;
    logic        [30:0] ws;
    logic        [30:0] sm;
    logic               bad;
  } flux_beat_t;

  typedef struct packed {
    logic signed [63:0] f0;
    logic signed [63:0] f1;
    logic signed [63:0] f2;
    logic signed [63:0] f3;
    logic signed [63:0] lam;
    logic               bad;
  } side_flux_t;

  // register copies and running minimum
  longint gamma_q, cfl_q, width_q, height_q, restart_q, step_run;
  flux_beat_t expected_fluxes[$];

  assign pending = expected_fluxes.size();

  function automatic longint clip(longint v);
    if (v > QHI) return QHI;
    if (v < QLO) return QLO;
    return v;
  endfunction

  function automatic longint unsigned magn(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint signed_mag(longint unsigned m, bit neg);
    if (m > 64'd2147483648) m = 64'd2147483648;
    return clip(neg ? -longint'(m) : longint'(m));
  endfunction

  function automatic longint q_add(longint a, longint b);
    return clip(a + b);
  endfunction

  function automatic longint q_sub(longint a, longint b);
    return clip(a - b);
  endfunction

  function automatic longint q_half(longint a);
    return a / 2;
  endfunction

  function automatic longint q_mul(longint a, longint b);
    return signed_mag((magn(a) * magn(b)) >> 16, (a < 0) != (b < 0));
  endfunction

  function automatic longint q_div(longint a, longint b);
    if (b == 0) begin
      if (a == 0) return 0;
      return a > 0 ? QHI : QLO;
    end
    return signed_mag((magn(a) << 16) / magn(b), (a < 0) != (b < 0));
  endfunction

  // bitwise integer root of a << 16
  function automatic longint q_root(longint a);
    longint unsigned x, r, b;
    if (a <= 0) return 0;
    x = longint'(a) << 16;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return clip(longint'(r));
  endfunction

  // pressure, physical flux and signal speed of one side
  function automatic side_flux_t side_flux(longint rho, longint mx, longint my, longint e,
                                           bit ydir);
    side_flux_t s;
    longint mn, mt, kin, p, vel, fn, ft;
    mn  = ydir ? my : mx;
    mt  = ydir ? mx : my;
    kin = q_half(q_div(q_add(q_mul(mx, mx), q_mul(my, my)), rho));
    p   = q_mul(q_sub(e, kin), q_sub(gamma_q, UNIT));
    vel = q_div(mn, rho);
    fn  = q_add(q_div(q_mul(mn, mn), rho), p);
    ft  = q_div(q_mul(mn, mt), rho);
    s.f0  = mn;
    s.f1  = ydir ? ft : fn;
    s.f2  = ydir ? fn : ft;
    s.f3  = q_mul(vel, q_add(e, p));
    s.lam = q_add(clip(longint'(magn(vel))), q_root(q_div(q_mul(gamma_q, p), rho)));
    s.bad = (rho <= 0) || (p <= 0);
    return s;
  endfunction

  function automatic longint blend(longint fl, longint fr, longint ul, longint ur,
                                   longint lmax, longint h);
    return q_div(q_sub(q_half(q_add(fl, fr)), q_half(q_mul(lmax, q_sub(ur, ul)))), h);
  endfunction

  // interface flux; folds the step candidate into step_run
  function flux_beat_t rusanov_flux();
    flux_beat_t x;
    side_flux_t sl, sr;
    longint ul[4], ur[4], lmax, h, cand;
    ul[0] = longint'(left_density);  ul[1] = longint'(left_mom_x);
    ul[2] = longint'(left_mom_y);    ul[3] = longint'(left_energy);
    ur[0] = longint'(right_density); ur[1] = longint'(right_mom_x);
    ur[2] = longint'(right_mom_y);   ur[3] = longint'(right_energy);
    sl = side_flux(ul[0], ul[1], ul[2], ul[3], func);
    sr = side_flux(ur[0], ur[1], ur[2], ur[3], func);
    lmax = sl.lam > sr.lam ? sl.lam : sr.lam;
    h = func ? height_q : width_q;
    x.fd  = 32'(blend(sl.f0, sr.f0, ul[0], ur[0], lmax, h));
    x.fmx = 32'(blend(sl.f1, sr.f1, ul[1], ur[1], lmax, h));
    x.fmy = 32'(blend(sl.f2, sr.f2, ul[2], ur[2], lmax, h));
    x.fe  = 32'(blend(sl.f3, sr.f3, ul[3], ur[3], lmax, h));
    if (new_sweep) step_run = restart_q;
    cand = (lmax == 0) ? QHI : q_div(q_mul(cfl_q, h), lmax);
    if (cand < 0) cand = 0;
    if (cand < step_run) step_run = cand;
    x.ws  = lmax[30:0];
    x.sm  = step_run[30:0];
    x.bad = sl.bad || sr.bad;
    return x;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
    errors = errors + 1;
  endtask

  initial errors = 0;

  // watch the three channels
  always @(posedge clk) begin
    flux_beat_t want;
    if (rst) begin
      gamma_q   = 91750;
      cfl_q     = 32768;
      width_q   = 65536;
      height_q  = 65536;
      restart_q = QHI;
      step_run  = QHI;
      expected_fluxes.delete();
    end else begin
      // result beat against oldest expectation
      if (out_valid && out_ready) begin
        if (expected_fluxes.size() == 0) begin
          report("unexpected result", 0, 0);
        end else begin
          want = expected_fluxes.pop_front();
          if (flux_density !== want.fd) report("flux_density", flux_density, want.fd);
          if (flux_mom_x !== want.fmx) report("flux_mom_x", flux_mom_x, want.fmx);
          if (flux_mom_y !== want.fmy) report("flux_mom_y", flux_mom_y, want.fmy);
          if (flux_energy !== want.fe) report("flux_energy", flux_energy, want.fe);
          if (wave_speed !== want.ws) report("wave_speed", wave_speed, want.ws);
          if (step_min !== want.sm) report("step_min", step_min, want.sm);
          if (bad_state !== want.bad) report("bad_state", bad_state, want.bad);
        end
      end
      // register write
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GAMMA:  gamma_q   = longint'(cfg_data[17:0]);
          REG_CFL:    cfl_q     = longint'(cfg_data[16:0]);
          REG_WIDTH:  width_q   = longint'(cfg_data[30:0]);
          REG_HEIGHT: height_q  = longint'(cfg_data[30:0]);
          REG_START:  restart_q = longint'(cfg_data[30:0]);
          default: ;
        endcase
      end
      // interface beat
      if (in_valid && in_ready) expected_fluxes.push_back(rusanov_flux());
    end
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
module tb;
  import erif_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int HOLD_CYCLES = 3000;

  typedef struct packed {
    logic        func;
    logic [31:0] ld, lmx, lmy, le;
    logic [31:0] rd, rmx, rmy, re;
    logic        ns;
  } iface_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = 1'b0;
  logic signed [31:0] left_density = '0, left_mom_x = '0, left_mom_y = '0, left_energy = '0;
  logic signed [31:0] right_density = '0, right_mom_x = '0, right_mom_y = '0;
  logic signed [31:0] right_energy = '0;
  logic new_sweep = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] flux_density, flux_mom_x, flux_mom_y, flux_energy;
  logic [30:0] wave_speed, step_min;
  logic bad_state;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = REG_GAMMA;
  logic [31:0] cfg_data = '0;

  int errors, pending;
  int cycle_count = 0;
  bit no_gaps = 1'b0;
  bit hold_req = 1'b0;

  euler_rusanov_interface_flux_unit dut (.*);

  rusanov_flux_checker chk (.*);

  initial forever #6 clk = ~clk;

  // sender side: one interface per call, entered at a falling edge
  task automatic offer(input iface_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= it.func;
    left_density <= it.ld;  left_mom_x <= it.lmx;  left_mom_y <= it.lmy;  left_energy <= it.le;
    right_density <= it.rd; right_mom_x <= it.rmx; right_mom_y <= it.rmy; right_energy <= it.re;
    new_sweep <= it.ns;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // drain all interfaces, then load a full register set
  task automatic load_regs(input logic [31:0] g, c, w, h, s);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    write_reg(REG_GAMMA, g);
    write_reg(REG_CFL, c);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_START, s);
  endtask

  function automatic iface_t mk(logic f, logic [31:0] ld, lmx, lmy, le,
                                logic [31:0] rd, rmx, rmy, re, logic ns);
    iface_t it;
    it.func = f; it.ld = ld; it.lmx = lmx; it.lmy = lmy; it.le = le;
    it.rd = rd; it.rmx = rmx; it.rmy = rmy; it.re = re; it.ns = ns;
    return it;
  endfunction

  function automatic logic [31:0] edge_word();
    case ($urandom_range(0, 6))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hffff_ffff;
      3: return 32'h7fff_ffff;
      4: return 32'h8000_0000;
      5: return 32'h0001_0000;
      default: return $urandom;
    endcase
  endfunction

  // mostly physical states with random content, some edge and raw noise
  function automatic iface_t draw_iface();
    iface_t it;
    int kind;
    kind = $urandom_range(0, 99);
    it.func = 1'($urandom_range(0, 1));
    it.ns = ($urandom_range(0, 7) == 0);
    if (kind < 70) begin
      it.ld  = $urandom_range(4096, 1 << 20);
      it.rd  = $urandom_range(4096, 1 << 20);
      it.lmx = $urandom_range(0, 1 << 19) - (1 << 18);
      it.lmy = $urandom_range(0, 1 << 19) - (1 << 18);
      it.rmx = $urandom_range(0, 1 << 19) - (1 << 18);
      it.rmy = $urandom_range(0, 1 << 19) - (1 << 18);
      it.le  = $urandom_range(1 << 16, 1 << 22);
      it.re  = $urandom_range(1 << 16, 1 << 22);
    end else if (kind < 85) begin
      it.ld = edge_word(); it.lmx = edge_word(); it.lmy = edge_word(); it.le = edge_word();
      it.rd = edge_word(); it.rmx = edge_word(); it.rmy = edge_word(); it.re = edge_word();
    end else begin
      it.ld = $urandom; it.lmx = $urandom; it.lmy = $urandom; it.le = $urandom;
      it.rd = $urandom; it.rmx = $urandom; it.rmy = $urandom; it.re = $urandom;
    end
    return it;
  endfunction

  // receiver side with random stalls and one long hold-off
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (hold_req) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // cycle budget
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("euler_rusanov_interface_flux_unit test failed");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // default-like settings and directed interfaces
    load_regs(91750, 32768, 65536, 65536, 32'h7fff_ffff);
    offer(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    offer(mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    offer(mk(0, 65536, 0, 0, 163840, 65536, 0, 0, 163840, 0));
    offer(mk(1, 65536, 32768, -16384, 163840, 65536, 32768, -16384, 163840, 0));
    offer(mk(0, 655360, 0, 0, 1638400, 8192, 0, 0, 16384, 0));
    offer(mk(1, 655360, 0, 0, 1638400, 8192, 0, 0, 16384, 0));
    offer(mk(0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0));
    offer(mk(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0));
    offer(mk(0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
             32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1));
    // zero density with momentum, negative density, negative pressure
    offer(mk(0, 0, 65536, -65536, 65536, 65536, 0, 0, 65536, 0));
    offer(mk(1, -65536, 1000, 2000, 131072, 65536, 0, 0, 131072, 0));
    offer(mk(0, 65536, 131072, 0, 0, 65536, 0, 0, -65536, 0));
    // tiny density with large momentum, saturating the fluxes
    offer(mk(1, 1, 32'h4000_0000, 32'hc000_0000, 32'h7fff_ffff,
             1, 1, 1, 1, 0));
    offer(mk(0, 65536, 1, 1, 65536, 65536, -1, -1, 65536, 0));
    // step minimum restarts then folds
    offer(mk(0, 65536, 0, 0, 6553600, 65536, 0, 0, 6553600, 1));
    offer(mk(1, 65536, 0, 0, 163840, 65536, 0, 0, 163840, 0));
    offer(mk(0, 65536, 0, 0, 163840, 65536, 0, 0, 163840, 1));

    // smallest gamma, zero cfl, extreme cell sizes, zero restart
    load_regs(65537, 0, 1, 32'h7fff_ffff, 0);
    repeat (130) offer(draw_iface());

    // largest gamma and cfl, back-to-back beats
    load_regs(196608, 65536, 32'h7fff_ffff, 1, 32'h7fff_ffff);
    no_gaps = 1'b1;
    repeat (70) offer(draw_iface());
    no_gaps = 1'b0;
    repeat (70) offer(draw_iface());

    // mid-range random settings, receiver holds off for a while
    load_regs($urandom_range(65537, 196608), $urandom_range(0, 65536),
              $urandom_range(4096, 1 << 20), $urandom_range(4096, 1 << 20),
              $urandom_range(0, 32'h7fff_ffff));
    hold_req = 1'b1;
    repeat (140) offer(draw_iface());

    load_regs($urandom_range(65537, 196608), $urandom_range(0, 65536),
              $urandom_range(1, 32'h7fff_ffff), $urandom_range(1, 32'h7fff_ffff),
              $urandom_range(0, 32'h7fff_ffff));
    repeat (140) offer(draw_iface());

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("euler_rusanov_interface_flux_unit test passed");
    end else begin
      $display("euler_rusanov_interface_flux_unit test failed");
    end
    $finish;
  end

endmodule
